/* hdl/ihc_pkg.sv */
// ============================================================================
// ihc_pkg - shared types and constants for the IPv4 header checker
// Word formats for both channels, result codes and header byte offsets.
// ============================================================================
package ihc_pkg;

    // Default width of the saturating drop counters.
    localparam int COUNTER_BITS_DEF = 32;

    // Width of a counter as it appears in the result word.
    localparam int CNT_OUT_W = 32;

    // Smallest legal IPv4 header in bytes.
    localparam logic [16:0] MIN_HDR_BYTES = 17'd20;

    // Folded ones' complement sum of a correct header.
    localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

    // Saturation value of the packet byte index.
    localparam logic [15:0] IDX_MAX = 16'hFFFF;

    // Byte offsets of the captured header fields.
    localparam logic [15:0] IDX_IHL       = 16'd0;
    localparam logic [15:0] IDX_TOTLEN_HI = 16'd2;
    localparam logic [15:0] IDX_TOTLEN_LO = 16'd3;
    localparam logic [15:0] IDX_PROTO     = 16'd9;
    localparam logic [15:0] IDX_SRC_FIRST = 16'd12;
    localparam logic [15:0] IDX_SRC_LAST  = 16'd15;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_BAD_CSUM = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        status_t               status;
        logic [5:0]            header_len;
        logic [15:0]           payload_len;
        logic [7:0]            protocol;
        logic [31:0]           source_addr;
        logic [CNT_OUT_W-1:0]  bad_size_total;
        logic [CNT_OUT_W-1:0]  bad_checksum_total;
    } out_word_t;

    // Handshake between the input stage and the packet core.
    typedef struct packed {
        logic     valid;
        in_word_t word;
    } stage_t;

    // Ones' complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

/* hdl/ihc_in_stage.sv */
// ============================================================================
// ihc_in_stage - input register of the IPv4 header checker
// Holds one incoming word and releases it when the core takes it.
// ============================================================================
module ihc_in_stage
    import ihc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    input  logic     take,
    output stage_t   stage
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // The register refills in the same cycle that the core drains it.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

/* hdl/ihc_core.sv */
// ============================================================================
// ihc_core - per-packet state and checks of the IPv4 header checker
// Captures header fields, accumulates the checksum and forms the result.
// ============================================================================
module ihc_core
    import ihc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  word,
    output logic      res_valid,
    output out_word_t res_word
);

    logic [15:0] byte_index_reg, byte_index_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [5:0]  hdr_reg, hdr_next;
    logic [15:0] totlen_reg, totlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;

    logic [COUNTER_BITS-1:0] size_cnt_reg, size_cnt_next, size_cnt_inc;
    logic [COUNTER_BITS-1:0] csum_cnt_reg, csum_cnt_next, csum_cnt_inc;
    logic [CNT_OUT_W-1:0]    size_cnt_out, csum_cnt_out;

    logic        in_hdr;
    logic [16:0] count;
    logic        bad_size;
    logic        bad_csum;
    logic [15:0] payload;
    status_t     status;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        hdr_next    = (byte_index_reg == IDX_IHL) ? {word.data_byte[3:0], 2'b00} : hdr_reg;
        totlen_next = totlen_reg;
        proto_next  = proto_reg;
        src_next    = src_reg;
        if (byte_index_reg == IDX_TOTLEN_HI)
        begin
            totlen_next = {word.data_byte, 8'h00};
        end
        else if (byte_index_reg == IDX_TOTLEN_LO)
        begin
            totlen_next = {totlen_reg[15:8], word.data_byte};
        end
        else if (byte_index_reg == IDX_PROTO)
        begin
            proto_next = word.data_byte;
        end
        else if (byte_index_reg >= IDX_SRC_FIRST && byte_index_reg <= IDX_SRC_LAST)
        begin
            src_next = {src_reg[23:0], word.data_byte};
        end

        // Header bytes pair up into big-endian words for the checksum.
        in_hdr    = byte_index_reg < {10'd0, hdr_next};
        pend_next = (in_hdr && !byte_index_reg[0]) ? word.data_byte : pend_reg;
        sum_next  = (in_hdr && byte_index_reg[0]) ? oc_add(sum_reg, {pend_reg, word.data_byte})
                                                  : sum_reg;

        byte_index_next = (byte_index_reg == IDX_MAX) ? byte_index_reg
                                                      : byte_index_reg + 16'd1;

        count    = {1'b0, byte_index_reg} + 17'd1;
        bad_size = (count < MIN_HDR_BYTES) || (count < {11'd0, hdr_next});
        bad_csum = sum_next != CSUM_GOOD;

        size_cnt_inc = (size_cnt_reg == CNT_MAX) ? size_cnt_reg : size_cnt_reg + CNT_ONE;
        csum_cnt_inc = (csum_cnt_reg == CNT_MAX) ? csum_cnt_reg : csum_cnt_reg + CNT_ONE;
        size_cnt_next = size_cnt_reg;
        csum_cnt_next = csum_cnt_reg;
        if (bad_size)
        begin
            status        = ST_BAD_SIZE;
            size_cnt_next = size_cnt_inc;
        end
        else if (bad_csum)
        begin
            status        = ST_BAD_CSUM;
            csum_cnt_next = csum_cnt_inc;
        end
        else
        begin
            status = ST_OK;
        end

        payload = (totlen_next > {10'd0, hdr_next}) ? totlen_next - {10'd0, hdr_next} : 16'd0;
    end

    generate
        if (COUNTER_BITS >= CNT_OUT_W)
        begin : g_cnt_wide
            assign size_cnt_out = size_cnt_next[CNT_OUT_W-1:0];
            assign csum_cnt_out = csum_cnt_next[CNT_OUT_W-1:0];
        end
        else
        begin : g_cnt_narrow
            assign size_cnt_out = {{(CNT_OUT_W-COUNTER_BITS){1'b0}}, size_cnt_next};
            assign csum_cnt_out = {{(CNT_OUT_W-COUNTER_BITS){1'b0}}, csum_cnt_next};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            sum_reg        <= '0;
            pend_reg       <= '0;
            hdr_reg        <= '0;
            totlen_reg     <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            size_cnt_reg   <= '0;
            csum_cnt_reg   <= '0;
        end
        else if (step)
        begin
            if (word.last_byte)
            begin
                // The packet is done: start the next one from a clean slate.
                byte_index_reg <= '0;
                sum_reg        <= '0;
                pend_reg       <= '0;
                hdr_reg        <= '0;
                totlen_reg     <= '0;
                proto_reg      <= '0;
                src_reg        <= '0;
                size_cnt_reg   <= size_cnt_next;
                csum_cnt_reg   <= csum_cnt_next;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                sum_reg        <= sum_next;
                pend_reg       <= pend_next;
                hdr_reg        <= hdr_next;
                totlen_reg     <= totlen_next;
                proto_reg      <= proto_next;
                src_reg        <= src_next;
            end
        end
    end

    assign res_valid                   = step && word.last_byte;
    assign res_word.status             = status;
    assign res_word.header_len         = hdr_next;
    assign res_word.payload_len        = payload;
    assign res_word.protocol           = proto_next;
    assign res_word.source_addr        = src_next;
    assign res_word.bad_size_total     = size_cnt_out;
    assign res_word.bad_checksum_total = csum_cnt_out;

    a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        step && word.last_byte |=> byte_index_reg == '0 && sum_reg == '0)
        else $error("packet state not cleared after final byte");

    a_size_cnt_mono : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> size_cnt_reg >= $past(size_cnt_reg))
        else $error("bad size counter went backward");

    a_csum_cnt_mono : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> csum_cnt_reg >= $past(csum_cnt_reg))
        else $error("bad checksum counter went backward");

endmodule

/* hdl/ihc_out_stage.sv */
// ============================================================================
// ihc_out_stage - result register of the IPv4 header checker
// Holds one result word until the receiver takes it.
// ============================================================================
module ihc_out_stage
    import ihc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t load_word,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;

endmodule

/* hdl/ipv4_header_check.sv */
// ============================================================================
// ipv4_header_check - IPv4 header length and checksum checker
// Byte-wide packet input, one summary word per packet on the output.
// ============================================================================
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one packet byte
// per word, header first, with last_byte set on the final byte. The output
// channel (out_valid, out_ready, out_data) carries one word per packet: the
// status (ok, bad size or bad checksum), header length, payload length,
// protocol, source address and the two saturating drop counters.
// Throughput is one byte per cycle while the result slot can take a final
// byte; header bytes pass through the single 16-bit ones' complement add.
// A byte passes through the input register and the packet core, and the
// result of a final byte is registered in the output register.
// Reset clears all packet state, both counters and both valid flags; the
// block is ready for bytes as soon as reset is released.
// When the receiver stalls, the result word holds in the output register.
// Ordinary bytes keep flowing meanwhile; only the final byte of the next
// packet waits in the input register until the result slot frees up.
// ============================================================================
module ipv4_header_check
    import ihc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    stage_t    stage;
    logic      take;
    logic      slot_free;
    logic      res_valid;
    out_word_t res_word;

    // A final byte needs the result slot; any other byte goes straight through.
    assign take = stage.valid && (!stage.word.last_byte || slot_free);

    ihc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .take     (take),
        .stage    (stage)
    );

    ihc_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .word      (stage.word),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    ihc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_word (res_word),
        .free      (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid || out_ready))
        else $error("result written over a word not yet taken");

    a_take_needs_word : assert property (@(posedge clk) disable iff (!rst_n)
        take |-> stage.valid)
        else $error("core stepped without a byte in the input register");

    a_drain_clears : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !res_valid |=> !out_valid)
        else $error("result slot stayed full after the word was taken");

endmodule
